// File: design/sca_pkg.sv
`default_nettype none

package sca_pkg;

    localparam int ADDR_W    = 48;
    localparam int HDR_BYTES = 24;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_NO_PAGE     = 2'd1;
    localparam logic [1:0] ST_NOT_HANDLED = 2'd2;

    // Register index of region_base on the configuration port.
    localparam logic REG_REGION_BASE = 1'b0;

    typedef struct packed {
        logic              opcode;
        logic [15:0]       size_bytes;
        logic [15:0]       align_bytes;
        logic [ADDR_W-1:0] address;
    } req_word_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] slot_address;
    } rsp_word_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_INIT,
        S_RD_HDR,
        S_RD_LINK,
        S_ALLOC_UPD,
        S_UNLINK1,
        S_UNLINK2,
        S_FREE_UPD,
        S_RELINK,
        S_DONE
    } state_t;

    typedef struct packed {
        logic take_item;
        logic decode;
        logic init_step;
        logic rd_hdr;
        logic rd_link;
        logic alloc_upd;
        logic unlink1;
        logic unlink2;
        logic free_upd;
        logic relink;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic is_free;
        logic dec_done;
        logic dec_claim;
        logic init_last;
        logic goes_full;
        logic need_relink;
        logic out_free;
    } sts_t;

    // Bin of a small request: highest set bit of (n - 1) >> 2.
    function automatic logic [1:0] bin_of_size(input logic [15:0] n);
        logic [15:0] m;
        logic [1:0]  b;
        m = n - 16'd1;
        if (m[5])
        begin
            b = 2'd3;
        end
        else if (m[4])
        begin
            b = 2'd2;
        end
        else if (m[3])
        begin
            b = 2'd1;
        end
        else
        begin
            b = 2'd0;
        end
        return b;
    endfunction

endpackage

`default_nettype wire

// File: design/sca_ram.sv
`default_nettype none

module sca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: design/sca_ctrl.sv
`default_nettype none

module sca_ctrl
    import sca_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.take_item = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.decode = 1'b1;
                if (sts.dec_done)
                begin
                    state_next = S_DONE;
                end
                else if (sts.dec_claim)
                begin
                    state_next = S_INIT;
                end
                else
                begin
                    state_next = S_RD_HDR;
                end
            end
            S_INIT:
            begin
                cmd.init_step = 1'b1;
                if (sts.init_last)
                begin
                    state_next = S_RD_HDR;
                end
            end
            S_RD_HDR:
            begin
                cmd.rd_hdr = 1'b1;
                state_next = S_RD_LINK;
            end
            S_RD_LINK:
            begin
                cmd.rd_link = 1'b1;
                state_next  = sts.is_free ? S_FREE_UPD : S_ALLOC_UPD;
            end
            S_ALLOC_UPD:
            begin
                cmd.alloc_upd = 1'b1;
                state_next    = sts.goes_full ? S_UNLINK1 : S_DONE;
            end
            S_UNLINK1:
            begin
                cmd.unlink1 = 1'b1;
                state_next  = S_UNLINK2;
            end
            S_UNLINK2:
            begin
                cmd.unlink2 = 1'b1;
                state_next  = S_DONE;
            end
            S_FREE_UPD:
            begin
                cmd.free_upd = 1'b1;
                state_next   = sts.need_relink ? S_RELINK : S_DONE;
            end
            S_RELINK:
            begin
                cmd.relink = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: design/sca_dp.sv
`default_nettype none

module sca_dp
    import sca_pkg::*;
#(
    parameter int PAGES      = 64,
    parameter int PAGE_BYTES = 4096,
    parameter int SMALL_MAX  = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire req_word_t         req,
    input  wire cmd_t              cmd,
    output sts_t                   sts,
    input  wire logic              cfg_we,
    input  wire logic [ADDR_W-1:0] cfg_wdata,
    output logic      [ADDR_W-1:0] region_base,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output rsp_word_t              rsp
);

    localparam int PW    = $clog2(PAGES + 1);
    localparam int PIW   = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int OW    = $clog2(PAGE_BYTES);
    localparam int GW    = OW - 3;
    localparam int LAW   = PIW + GW;
    localparam int LDEPTH = PAGES * (PAGE_BYTES / 8);
    localparam int DATA_BYTES = PAGE_BYTES - HDR_BYTES;
    localparam logic [PW-1:0]     NIL = PW'(PAGES);
    localparam logic [OW+1:0]     DATA_LIM = (OW+2)'(DATA_BYTES);
    localparam logic [ADDR_W:0]   REGION_BYTES = (ADDR_W+1)'(PAGES * PAGE_BYTES);

    req_word_t         item_reg;
    logic [ADDR_W-1:0] base_reg;
    logic [PW-1:0]     head_reg [4];
    logic [PW-1:0]     head_next [4];
    logic [PW-1:0]     used_reg, used_next;
    logic [PW-1:0]     p_reg, p_next;
    logic [OW-1:0]     inpage_reg, inpage_next;
    logic [OW-1:0]     off_reg, off_next;
    logic [1:0]        bin_reg, bin_next;
    logic [PW-1:0]     rhead_reg, rhead_next;
    logic [1:0]        rstat_reg, rstat_next;
    logic [ADDR_W-1:0] raddr_reg, raddr_next;
    logic              ovalid_reg;
    rsp_word_t         out_reg;

    // Page header stores and the slot link store.
    logic              ff_we, pv_we, nx_we, lk_we, hdr_re, lk_re;
    logic [PIW-1:0]    ff_wa, pv_wa, nx_wa, hdr_ra;
    logic [OW+1:0]     ff_wd, ff_q;
    logic [PW-1:0]     pv_wd, nx_wd, pv_q, nx_q;
    logic [LAW-1:0]    lk_wa, lk_ra;
    logic [OW-1:0]     lk_wd, lk_q;

    sca_ram #(.WIDTH(OW + 2), .DEPTH(PAGES), .AW(PIW)) u_ff_ram (
        .clk(clk), .we(ff_we), .waddr(ff_wa), .wdata(ff_wd),
        .re(hdr_re), .raddr(hdr_ra), .rdata(ff_q));
    sca_ram #(.WIDTH(PW), .DEPTH(PAGES), .AW(PIW)) u_prev_ram (
        .clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd),
        .re(hdr_re), .raddr(hdr_ra), .rdata(pv_q));
    sca_ram #(.WIDTH(PW), .DEPTH(PAGES), .AW(PIW)) u_next_ram (
        .clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd),
        .re(hdr_re), .raddr(hdr_ra), .rdata(nx_q));
    sca_ram #(.WIDTH(OW), .DEPTH(LDEPTH), .AW(LAW)) u_link_ram (
        .clk(clk), .we(lk_we), .waddr(lk_wa), .wdata(lk_wd),
        .re(lk_re), .raddr(lk_ra), .rdata(lk_q));

    // Decode of the held word.
    logic [1:0]        d_bin;
    logic [PW-1:0]     d_head;
    logic              a_bad, head_ok, full;
    logic [ADDR_W:0]   diff;
    logic [PW-1:0]     f_page;
    logic              f_bad;
    logic [7:0]        sz, f_sz;
    logic [1:0]        f_bin;
    logic [OW-1:0]     ff_cur;
    logic [OW+1:0]     init_sum, nff_sum, cur_sum, slot_sum;
    logic              slot_bad, page_full;
    logic [PW-1:0]     f_head;

    always_comb
    begin
        d_bin   = bin_of_size(item_reg.size_bytes);
        d_head  = head_reg[d_bin];
        a_bad   = (item_reg.size_bytes == 16'd0)
                  || (item_reg.size_bytes > 16'(SMALL_MAX))
                  || (item_reg.align_bytes > item_reg.size_bytes);
        head_ok = d_head < used_reg;
        full    = used_reg >= NIL;
        diff    = {1'b0, item_reg.address} - {1'b0, base_reg};
        f_page  = PW'(diff[ADDR_W-1:0] >> OW);
        f_bad   = diff[ADDR_W] || (diff >= REGION_BYTES) || !(f_page < used_reg);

        sz        = 8'd8 << bin_reg;
        ff_cur    = ff_q[OW-1:0];
        f_bin     = ff_q[OW+1:OW];
        f_sz      = 8'd8 << f_bin;
        f_head    = head_reg[f_bin];
        init_sum  = (OW+2)'(off_reg) + (OW+2)'(sz) + (OW+2)'(sz);
        nff_sum   = (OW+2)'(lk_q) + (OW+2)'(sz);
        cur_sum   = (OW+2)'(ff_cur) + (OW+2)'(f_sz);
        slot_sum  = (OW+2)'(inpage_reg) + (OW+2)'(f_sz);
        slot_bad  = ((inpage_reg & OW'(f_sz - 8'd1)) != '0) || (slot_sum > DATA_LIM);
        page_full = cur_sum > DATA_LIM;

        sts.is_free     = item_reg.opcode == OP_FREE;
        sts.dec_done    = sts.is_free ? f_bad : (a_bad || (!head_ok && full));
        sts.dec_claim   = !sts.is_free && !a_bad && !head_ok && !full;
        sts.init_last   = init_sum > DATA_LIM;
        sts.goes_full   = nff_sum > DATA_LIM;
        sts.need_relink = !slot_bad && page_full && (f_head < used_reg);
        sts.out_free    = !ovalid_reg || rsp_ready;
    end

    always_comb
    begin
        for (int b = 0; b < 4; b++)
        begin
            head_next[b] = head_reg[b];
        end
        used_next   = used_reg;
        p_next      = p_reg;
        inpage_next = inpage_reg;
        off_next    = off_reg;
        bin_next    = bin_reg;
        rhead_next  = rhead_reg;
        rstat_next  = rstat_reg;
        raddr_next  = raddr_reg;
        ff_we = 1'b0; ff_wa = PIW'(p_reg); ff_wd = {bin_reg, {OW{1'b0}}};
        pv_we = 1'b0; pv_wa = PIW'(p_reg); pv_wd = NIL;
        nx_we = 1'b0; nx_wa = PIW'(p_reg); nx_wd = NIL;
        lk_we = 1'b0; lk_wa = {PIW'(p_reg), off_reg[OW-1:3]}; lk_wd = '0;
        hdr_re = cmd.rd_hdr;
        hdr_ra = PIW'(p_reg);
        lk_re  = cmd.rd_link;
        lk_ra  = {PIW'(p_reg), ff_cur[OW-1:3]};

        if (cmd.decode)
        begin
            raddr_next  = '0;
            rstat_next  = ST_OK;
            bin_next    = d_bin;
            inpage_next = diff[OW-1:0];
            if (sts.is_free)
            begin
                p_next = f_page;
                if (f_bad)
                begin
                    rstat_next = ST_NOT_HANDLED;
                end
            end
            else if (a_bad)
            begin
                rstat_next = ST_NOT_HANDLED;
            end
            else if (head_ok)
            begin
                p_next = d_head;
            end
            else if (full)
            begin
                rstat_next = ST_NO_PAGE;
            end
            else
            begin
                // Claim a fresh page and put it at the head of its bin.
                p_next          = used_reg;
                used_next       = used_reg + PW'(1);
                head_next[d_bin] = used_reg;
                off_next        = '0;
                ff_we = 1'b1; ff_wa = PIW'(used_reg); ff_wd = {d_bin, {OW{1'b0}}};
                pv_we = 1'b1; pv_wa = PIW'(used_reg);
                nx_we = 1'b1; nx_wa = PIW'(used_reg);
            end
        end

        if (cmd.init_step)
        begin
            lk_we    = 1'b1;
            lk_wd    = off_reg + OW'(sz);
            off_next = off_reg + OW'(sz);
        end

        if (cmd.alloc_upd)
        begin
            raddr_next = base_reg + (ADDR_W'(p_reg) << OW) + ADDR_W'(ff_cur);
            ff_we = 1'b1;
            ff_wd = {bin_reg, lk_q};
            if (sts.goes_full && (head_reg[bin_reg] == p_reg))
            begin
                head_next[bin_reg] = nx_q;
            end
        end

        if (cmd.unlink1)
        begin
            pv_we = nx_q < used_reg; pv_wa = PIW'(nx_q); pv_wd = pv_q;
            nx_we = pv_q < used_reg; nx_wa = PIW'(pv_q); nx_wd = nx_q;
        end

        if (cmd.unlink2)
        begin
            pv_we = 1'b1;
            nx_we = 1'b1;
        end

        if (cmd.free_upd)
        begin
            if (slot_bad)
            begin
                rstat_next = ST_NOT_HANDLED;
            end
            else
            begin
                if (page_full)
                begin
                    // A full page comes back at the head of its bin.
                    nx_we = 1'b1; nx_wd = f_head;
                    pv_we = 1'b1;
                    head_next[f_bin] = p_reg;
                    rhead_next = f_head;
                end
                lk_we = 1'b1;
                lk_wa = {PIW'(p_reg), inpage_reg[OW-1:3]};
                lk_wd = ff_cur;
                ff_we = 1'b1;
                ff_wd = {f_bin, inpage_reg};
            end
        end

        if (cmd.relink)
        begin
            pv_we = 1'b1; pv_wa = PIW'(rhead_reg); pv_wd = p_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < 4; b++)
            begin
                head_reg[b] <= NIL;
            end
            used_reg   <= '0;
            base_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            for (int b = 0; b < 4; b++)
            begin
                head_reg[b] <= head_next[b];
            end
            used_reg <= used_next;
            if (cfg_we)
            begin
                base_reg <= cfg_wdata;
            end
            if (cmd.load_out)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_item)
        begin
            item_reg <= req;
        end
        if (cmd.load_out)
        begin
            out_reg.status       <= rstat_reg;
            out_reg.slot_address <= raddr_reg;
        end
        p_reg      <= p_next;
        inpage_reg <= inpage_next;
        off_reg    <= off_next;
        bin_reg    <= bin_next;
        rhead_reg  <= rhead_next;
        rstat_reg  <= rstat_next;
        raddr_reg  <= raddr_next;
    end

    assign region_base = base_reg;
    assign rsp_valid   = ovalid_reg;
    assign rsp         = out_reg;

endmodule

`default_nettype wire

// File: design/size_class_slab_allocator.sv
`default_nettype none

// Small-object slab allocator over PAGES pages of PAGE_BYTES bytes (a power of
// two) from region_base, with bins of 8, 16, 32 and 64 byte slots. One request
// word is handled at a time, each giving one response word. An allocate from a
// listed page decodes the word, reads the page header then the slot link and
// updates the free chain; a page that fills is then unlinked (UNLINK1, UNLINK2).
// A fresh page first threads its free chain, one slot per cycle, over
// (PAGE_BYTES - 24) / slot_size slots. A free reads the same stores, updates
// the chain and relinks a full page. A request rejected by its size, alignment,
// address or a full region ends at the decode. The steps follow the dependent
// reads of the page header store and then the slot link store, each with a
// registered read. A new request word is taken while the last response waits.
module size_class_slab_allocator
    import sca_pkg::*;
#(
    parameter int PAGES      = 64,
    parameter int PAGE_BYTES = 4096,
    parameter int SMALL_MAX  = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_ready,
    input  wire req_word_t   req,
    output logic             rsp_valid,
    input  wire logic        rsp_ready,
    output rsp_word_t        rsp,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready
);

    cmd_t              cmd;
    sts_t              sts;
    logic              cfg_we;
    logic [ADDR_W-1:0] region_base;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[3] == REG_REGION_BASE);
    assign prdata = (paddr[3] == REG_REGION_BASE) ? 64'(region_base) : '0;

    sca_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .req_valid(req_valid), .req_ready(req_ready),
        .sts(sts), .cmd(cmd));

    sca_dp #(.PAGES(PAGES), .PAGE_BYTES(PAGE_BYTES), .SMALL_MAX(SMALL_MAX)) u_dp (
        .clk(clk), .rst_n(rst_n), .req(req), .cmd(cmd), .sts(sts),
        .cfg_we(cfg_we), .cfg_wdata(pwdata[ADDR_W-1:0]), .region_base(region_base),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp));

endmodule

`default_nettype wire

// File: sim/tb_size_class_slab_allocator.sv
`timescale 1ns / 1ps

module tb_size_class_slab_allocator;
    import sca_pkg::*;

    localparam int PAGES      = 64;
    localparam int PAGE_BYTES = 4096;
    localparam int SMALL_MAX  = 64;
    localparam int DATA_BYTES = PAGE_BYTES - HDR_BYTES;
    localparam int GRANS      = PAGE_BYTES / 8;
    localparam logic [6:0] NIL_PAGE = 7'd64;
    localparam logic [47:0] BASE_MAX = 48'hFFFF_FFFF_FFFF;
    localparam int QUIET_LIMIT = 6000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    req_word_t   req = '0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    rsp_word_t   rsp;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    // Shadow state of the allocator.
    logic [47:0] base_reg;
    logic [6:0]  bin_head [4];
    logic [6:0]  pages_used;
    logic [12:0] free_head [PAGES];
    logic [1:0]  page_bin [PAGES];
    logic [6:0]  page_prev [PAGES];
    logic [6:0]  page_next [PAGES];
    logic [12:0] slot_links [PAGES*GRANS];

    rsp_word_t   expected_rsp[$];
    logic [47:0] live_slots[$];
    int          errors = 0;
    int          quiet_cycles = 0;
    bit          calm = 1'b0;
    int          rsp_stall = 0;

    size_class_slab_allocator i_dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #2 clk = ~clk;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 65)
            return 0;
        else if (r < 94)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic logic [1:0] size_bin(input int n);
        int t;
        int b;
        t = (n - 1) >> 2;
        b = 0;
        while (t > 1)
        begin
            t = t >> 1;
            b++;
        end
        return b[1:0];
    endfunction

    function automatic bit page_claimed(input logic [6:0] p);
        return p < pages_used && p < PAGES;
    endfunction

    function automatic void drop_page(input logic [6:0] p, input logic [1:0] b);
        logic [6:0] nx;
        logic [6:0] pv;
        nx = page_next[p];
        pv = page_prev[p];
        if (bin_head[b] == p)
            bin_head[b] = nx;
        if (page_claimed(nx))
            page_prev[nx] = pv;
        if (page_claimed(pv))
            page_next[pv] = nx;
        page_next[p] = NIL_PAGE;
        page_prev[p] = NIL_PAGE;
    endfunction

    function automatic rsp_word_t predict_alloc(input int size, input int align);
        rsp_word_t  r;
        logic [1:0] b;
        int         sz;
        logic [6:0] p;
        logic [12:0] ff;
        r = '0;
        if (size == 0 || size > SMALL_MAX || align > size)
        begin
            r.status = ST_NOT_HANDLED;
            return r;
        end
        b = size_bin(size);
        sz = 8 << b;
        p = bin_head[b];
        if (!page_claimed(p))
        begin
            if (pages_used >= PAGES)
            begin
                r.status = ST_NO_PAGE;
                return r;
            end
            p = pages_used;
            free_head[p] = '0;
            page_bin[p] = b;
            page_prev[p] = NIL_PAGE;
            page_next[p] = NIL_PAGE;
            for (int i = 0; i < DATA_BYTES / sz; i++)
                slot_links[p*GRANS + ((i*sz) >> 3)] = 13'(i*sz + sz);
            bin_head[b] = p;
            pages_used++;
        end
        ff = free_head[p];
        r.status = ST_OK;
        r.slot_address = base_reg + 48'(p) * PAGE_BYTES + 48'(ff);
        free_head[p] = slot_links[p*GRANS + (ff >> 3)];
        if (int'(free_head[p]) + sz > DATA_BYTES)
            drop_page(p, b);
        live_slots.push_back(r.slot_address);
        return r;
    endfunction

    function automatic rsp_word_t predict_free(input logic [47:0] a);
        rsp_word_t  r;
        logic [47:0] off;
        logic [6:0] p;
        int         in_page;
        logic [1:0] b;
        int         sz;
        r = '0;
        r.status = ST_NOT_HANDLED;
        if (a < base_reg)
            return r;
        off = a - base_reg;
        if (off >= 48'(PAGES * PAGE_BYTES))
            return r;
        p = 7'(off / PAGE_BYTES);
        in_page = int'(off % PAGE_BYTES);
        if (!page_claimed(p))
            return r;
        b = page_bin[p];
        sz = 8 << b;
        if (in_page % sz != 0 || in_page + sz > DATA_BYTES)
            return r;
        if (int'(free_head[p]) + sz > DATA_BYTES)
        begin
            // Full page goes back to the head of its list.
            page_next[p] = bin_head[b];
            page_prev[p] = NIL_PAGE;
            if (page_claimed(bin_head[b]))
                page_prev[bin_head[b]] = p;
            bin_head[b] = p;
        end
        slot_links[p*GRANS + (in_page >> 3)] = free_head[p];
        free_head[p] = 13'(in_page);
        r.status = ST_OK;
        return r;
    endfunction

    task automatic send_word(input req_word_t w);
        int g;
        @(negedge clk);
        req_valid <= 1'b1;
        req <= w;
        do
            @(posedge clk);
        while (!req_ready);
        if (w.opcode == OP_ALLOC)
            expected_rsp.push_back(predict_alloc(int'(w.size_bytes),
                                                 int'(w.align_bytes)));
        else
            expected_rsp.push_back(predict_free(w.address));
        g = gap_len();
        if (g > 0)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
            repeat (g - 1) @(negedge clk);
        end
    endtask

    task automatic send_alloc(input int size, input int align);
        req_word_t w;
        w = '0;
        w.opcode = OP_ALLOC;
        w.size_bytes = 16'(size);
        w.align_bytes = 16'(align);
        w.address = 48'({$urandom, $urandom});
        send_word(w);
    endtask

    task automatic send_free(input logic [47:0] a);
        req_word_t w;
        w = '0;
        w.opcode = OP_FREE;
        w.size_bytes = 16'($urandom);
        w.align_bytes = 16'($urandom);
        w.address = a;
        send_word(w);
    endtask

    task automatic drain();
        @(negedge clk);
        req_valid <= 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_base(input logic [47:0] v);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 4'(REG_REGION_BASE) * 4'd8;
        pwdata <= {16'h0, v};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        base_reg = v;
        live_slots.delete();
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic test_directed();
        logic [47:0] b;
        b = 48'h0000_1234_5000;
        write_base(b);
        send_alloc(0, 1);
        send_alloc(65, 1);
        send_alloc(65535, 65535);
        send_alloc(8, 16);
        send_alloc(1, 1);
        send_alloc(8, 8);
        send_alloc(9, 1);
        send_alloc(16, 16);
        send_alloc(17, 4);
        send_alloc(32, 32);
        send_alloc(33, 1);
        send_alloc(64, 64);
        send_free(b + 48'd8);
        send_free(b + 48'd8);
        send_free(b + 48'd3);
        send_free(b + 48'd4072);
        send_free(b - 48'd8);
        send_free(b + 48'(PAGES * PAGE_BYTES));
        send_free(b + 48'(40 * PAGE_BYTES));
        send_free(48'h0);
        send_free(BASE_MAX);
        send_alloc(8, 1);
        send_alloc(8, 1);
        drain();
    endtask

    task automatic random_items(input int count);
        int r;
        int k;
        int s;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 50 || (r < 85 && live_slots.size() == 0))
            begin
                s = $urandom_range(1, SMALL_MAX);
                send_alloc(s, $urandom_range(1, s));
            end
            else if (r < 80)
            begin
                k = $urandom_range(0, live_slots.size() - 1);
                send_free(live_slots[k]);
                live_slots.delete(k);
            end
            else if (r < 85)
                send_free(live_slots[$urandom_range(0, live_slots.size() - 1)]);
            else if (r < 90)
                send_free(base_reg + 48'($urandom_range(0, pages_used)) * PAGE_BYTES
                          + 48'($urandom_range(0, PAGE_BYTES - 1)));
            else if (r < 95)
                send_alloc($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 65535),
                           $urandom_range(1, 65535));
            else
                send_free(48'({$urandom, $urandom}));
        end
        drain();
    endtask

    task automatic test_random();
        write_base(48'h0);
        random_items(300);
        write_base(BASE_MAX);
        random_items(150);
        calm = 1'b1;
        write_base(48'({$urandom, $urandom}) & 48'hFFFF_FFFF_F000);
        random_items(150);
        calm = 1'b0;
        // Hold off sending until the block has answered everything.
        while (expected_rsp.size() != 0)
            @(posedge clk);
        random_items(350);
    endtask

    always @(negedge clk)
    begin
        if (rsp_stall > 0)
        begin
            rsp_stall <= rsp_stall - 1;
            rsp_ready <= 1'b0;
        end
        else
        begin
            rsp_ready <= 1'b1;
            if (!calm && $urandom_range(0, 99) < 20)
                rsp_stall <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                         : $urandom_range(1, 3);
        end
    end

    always @(posedge clk)
    begin
        if (rsp_valid && rsp_ready)
        begin
            if (expected_rsp.size() == 0)
            begin
                $display("%0t: unexpected word status=%0d addr=%h", $time,
                         rsp.status, rsp.slot_address);
                errors++;
            end
            else
            begin
                if (rsp.status !== expected_rsp[0].status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             expected_rsp[0].status, rsp.status);
                    errors++;
                end
                if (rsp.slot_address !== expected_rsp[0].slot_address)
                begin
                    $display("%0t: slot_address expected %h actual %h", $time,
                             expected_rsp[0].slot_address, rsp.slot_address);
                    errors++;
                end
                void'(expected_rsp.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no progress", $time);
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        base_reg = '0;
        pages_used = '0;
        for (int b = 0; b < 4; b++)
            bin_head[b] = NIL_PAGE;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random();
        if (errors == 0 && expected_rsp.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: size_class_slab_allocator.f
design/sca_pkg.sv
design/sca_ram.sv
design/sca_ctrl.sv
design/sca_dp.sv
design/size_class_slab_allocator.sv
sim/tb_size_class_slab_allocator.sv
